FILE: src/can_id_change_monitor_defines.svh
`ifndef CAN_ID_CHANGE_MONITOR_DEFINES_SVH
`define CAN_ID_CHANGE_MONITOR_DEFINES_SVH

// same-cycle implication, off during reset
`define CICM_ASSERT_NOW(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("cicm check failed");

// next-cycle implication, checked during reset too
`define CICM_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) (lhs) |=> (rhs)) \
      else $error("cicm check failed");

`endif

FILE: src/cicm_pkg.sv
package cicm_pkg;

   localparam int TABLE_ENTRIES_DEF = 2048;
   localparam int ID_W              = 11;
   localparam int QUOT_SHIFT        = 22;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 16;

   localparam logic [3:0] LEN_MAX   = 4'd8;
   localparam logic [6:0] DELTA_MAX = 7'd99;

   localparam logic REQ_FRAME  = 1'b0;
   localparam logic REQ_SWEEP  = 1'b1;
   localparam logic REC_LINE   = 1'b0;
   localparam logic REC_REMOVE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd1;

   typedef struct packed {
      logic            req_type;
      logic [ID_W-1:0] entry_id;
      logic [3:0]      frame_len;
      logic [63:0]     frame_payload;
      logic [31:0]     now_ticks;
      logic            sweep_first;
   } req_item_type;

   typedef struct packed {
      logic            record_kind;
      logic [ID_W-1:0] line_id;
      logic [3:0]      line_len;
      logic [63:0]     line_payload;
      logic [63:0]     changed_bits;
      logic [3:0]      shrink_count;
      logic [6:0]      delta_ticks;
      logic            redraw_all;
      logic            last_of_run;
   } rsp_item_type;

   typedef struct packed {
      req_item_type    req;
      logic [ID_W-1:0] quot;
   } fe_item_type;

   typedef struct packed {
      logic        valid;
      fe_item_type item;
   } fe_link_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] hold_ticks;
      logic [CSR_DATA_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        shown;
      logic        update;
      logic        seen;
      logic [31:0] hold_dl;
      logic [31:0] timeout_dl;
      logic [63:0] cur_payload;
      logic [63:0] prev_payload;
      logic [63:0] mask;
      logic [3:0]  cur_len;
      logic [3:0]  prev_len;
      logic [31:0] cur_stamp;
      logic [31:0] prev_stamp;
   } entry_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } back_state_type;

endpackage

FILE: src/cicm_ram.sv
module cicm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: src/cicm_front.sv
module cicm_front #(
   parameter int TABLE_ENTRIES = cicm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cicm_pkg::req_item_type push_data,
   output logic                  full,
   output cicm_pkg::fe_link_type link,
   input  logic                  take
);
   import cicm_pkg::*;

   localparam int RECIP_W = QUOT_SHIFT - $clog2(TABLE_ENTRIES) + 2;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** QUOT_SHIFT) + TABLE_ENTRIES - 1) / TABLE_ENTRIES);
   localparam int PROD_W = ID_W + RECIP_W;

   fe_item_type        q_ff [2];
   logic               wptr_ff, wptr_in;
   logic               rptr_ff, rptr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [PROD_W-1:0]  prod;
   fe_item_type        enq;

   // index quotient by reciprocal multiply, exact for 11-bit identifiers
   always_comb begin
      prod     = PROD_W'(push_data.entry_id) * PROD_W'(RECIP);
      enq.req  = push_data;
      enq.quot = ID_W'(prod >> QUOT_SHIFT);
   end

   assign full       = (cnt_ff == 2'd2);
   assign link.valid = (cnt_ff != 2'd0);
   assign link.item  = q_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff + (push ? 1'b1 : 1'b0);
      rptr_in = rptr_ff + (take ? 1'b1 : 1'b0);
      cnt_in  = cnt_ff + (push ? 2'd1 : 2'd0) - (take ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= enq;
      end
   end

endmodule

FILE: src/cicm_back.sv
module cicm_back #(
   parameter int TABLE_ENTRIES = cicm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cicm_pkg::cfg_type      cfg,
   input  cicm_pkg::fe_link_type  link,
   output logic                   take,
   output logic                   init_busy,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output cicm_pkg::rsp_item_type rsp_data
);
   import cicm_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int EW = $bits(entry_type);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

   back_state_type  state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   addr_ff, addr_in;
   req_item_type    item_ff, item_in;
   logic            rp_ff, rp_in;
   logic            rts_ff, rts_in;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr;
   logic [EW-1:0]   wr_data, rd_data;
   logic [2*ID_W-1:0] qn;
   logic [ID_W-1:0] rem;

   rsp_item_type    outq_ff [4];
   logic [1:0]      wptr_ff, rptr_ff;
   logic [2:0]      ocnt_ff;
   logic [1:0]      push_n;
   rsp_item_type    rec0, rec1, line_rec, rm_rec;
   logic            pop;

   entry_type       ent, nxt;
   logic [3:0]      len;
   logic            same, rts_eff, do_line, do_rm, hold_exp;
   logic [31:0]     d, now;
   logic [6:0]      dsat;

   cicm_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_in),
      .rd_data (rd_data)
   );

   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_empty = (ocnt_ff == 3'd0);
   assign rsp_data  = outq_ff[rptr_ff];
   assign init_busy = (state_ff == ST_INIT);

   always_comb begin
      qn  = (2*ID_W)'(link.item.quot) * (2*ID_W)'(TABLE_ENTRIES);
      rem = link.item.req.entry_id - qn[ID_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      addr_in  = rem[AW-1:0];
      item_in  = item_ff;
      rp_in    = rp_ff;
      rts_in   = rts_ff;
      take     = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = '0;
      push_n   = 2'd0;
      rec0     = '0;
      rec1     = '0;

      ent      = entry_type'(rd_data);
      nxt      = ent;
      now      = item_ff.now_ticks;
      len      = (item_ff.frame_len > LEN_MAX) ? LEN_MAX : item_ff.frame_len;
      same     = ent.seen && (len == ent.cur_len) &&
                 (item_ff.frame_payload == ent.cur_payload);
      rts_eff  = item_ff.sweep_first ? rp_ff : rts_ff;
      hold_exp = (ent.hold_dl != 32'd0) && (ent.hold_dl < now);
      do_line  = ent.shown && (ent.update || rts_eff || hold_exp);
      do_rm    = ent.shown && (ent.timeout_dl != 32'd0) && (ent.timeout_dl < now);
      d        = ent.cur_stamp - ent.prev_stamp;
      dsat     = d[31] ? 7'd0 : ((d > 32'(DELTA_MAX)) ? DELTA_MAX : d[6:0]);

      line_rec              = '0;
      line_rec.record_kind  = REC_LINE;
      line_rec.line_id      = item_ff.entry_id;
      line_rec.line_len     = ent.cur_len;
      line_rec.line_payload = ent.cur_payload;
      line_rec.changed_bits = (ent.update || rts_eff) ? ent.mask : 64'd0;
      line_rec.shrink_count = (ent.prev_len > ent.cur_len) ?
                              (ent.prev_len - ent.cur_len) : 4'd0;
      line_rec.delta_ticks  = dsat;
      line_rec.redraw_all   = rts_eff;
      rm_rec                = '0;
      rm_rec.record_kind    = REC_REMOVE;
      rm_rec.line_id        = item_ff.entry_id;

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (link.valid && (ocnt_ff <= 3'd2)) begin
               take     = 1'b1;
               rd_en    = 1'b1;
               item_in  = link.item.req;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (item_ff.req_type == REQ_FRAME) begin
               if (!same) begin
                  wr_en           = 1'b1;
                  nxt.seen        = 1'b1;
                  nxt.cur_payload = item_ff.frame_payload;
                  nxt.cur_len     = len;
                  nxt.cur_stamp   = now;
                  nxt.mask        = ent.mask | (item_ff.frame_payload ^ ent.prev_payload);
                  nxt.timeout_dl  = (cfg.timeout_ticks != '0) ?
                                    (now + 32'(cfg.timeout_ticks)) : 32'd0;
                  nxt.shown       = 1'b1;
                  nxt.update      = 1'b1;
                  if (!ent.shown) begin
                     rp_in = 1'b1;
                  end
               end
            end else begin
               wr_en = 1'b1;
               if (item_ff.sweep_first) begin
                  rts_in = rp_ff;
                  rp_in  = 1'b0;
               end
               if (ent.shown) begin
                  if (ent.update || rts_eff) begin
                     nxt.hold_dl = now + 32'(cfg.hold_ticks);
                     nxt.update  = 1'b0;
                     nxt.mask    = 64'd0;
                  end else if (hold_exp) begin
                     nxt.hold_dl = 32'd0;
                     nxt.mask    = 64'd0;
                  end
                  if (do_rm) begin
                     nxt.shown  = 1'b0;
                     nxt.update = 1'b0;
                     rp_in      = 1'b1;
                  end
               end
               nxt.prev_payload = ent.cur_payload;
               nxt.prev_len     = ent.cur_len;
               nxt.prev_stamp   = ent.cur_stamp;
               if (do_line && do_rm) begin
                  push_n = 2'd2;
                  rec0   = line_rec;
                  rec1   = rm_rec;
                  rec1.last_of_run = 1'b1;
               end else if (do_line) begin
                  push_n = 2'd1;
                  rec0   = line_rec;
                  rec0.last_of_run = 1'b1;
               end else if (do_rm) begin
                  push_n = 2'd1;
                  rec0   = rm_rec;
                  rec0.last_of_run = 1'b1;
               end
            end
            wr_data = EW'(nxt);
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         clr_ff   <= '0;
         rp_ff    <= 1'b1;
         rts_ff   <= 1'b0;
         wptr_ff  <= 2'd0;
         rptr_ff  <= 2'd0;
         ocnt_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rp_ff    <= rp_in;
         rts_ff   <= rts_in;
         wptr_ff  <= wptr_ff + push_n;
         rptr_ff  <= rptr_ff + (pop ? 2'd1 : 2'd0);
         ocnt_ff  <= ocnt_ff + 3'(push_n) - (pop ? 3'd1 : 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         addr_ff <= addr_in;
      end
      item_ff <= item_in;
      if (push_n != 2'd0) begin
         outq_ff[wptr_ff] <= rec0;
      end
      if (push_n == 2'd2) begin
         outq_ff[wptr_ff + 2'd1] <= rec1;
      end
   end

endmodule

FILE: src/can_id_change_monitor.sv
// channel | direction | handshake        | payload
// req     | in        | req_push/full    | req_data  (frame or sweep visit)
// rsp     | out       | rsp_pop/empty    | rsp_data  (line or removal record)
// csr     | in        | csr_valid/ready  | csr_index, csr_data
//
// Each item passes the back end as a table read, then a read-modify-write;
// the table read is registered, and the back end takes no new item before
// that write is done. After reset a clearing pass zeroes the table;
// req_full stays high meanwhile. Up to two items wait in the front queue,
// up to four records in the result queue; a stalled rsp side stops the
// back end only when fewer than two result slots are free.
module can_id_change_monitor #(
   parameter int TABLE_ENTRIES = cicm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  cicm_pkg::req_item_type            req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output cicm_pkg::rsp_item_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cicm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cicm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cicm_pkg::*;

   cfg_type     cfg_ff;
   fe_link_type link;
   logic        fe_full, take, init_busy, push;

   assign req_full  = fe_full || init_busy;
   assign push      = req_push && !req_full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HOLD:    cfg_ff.hold_ticks    <= csr_data;
            CSR_TIMEOUT: cfg_ff.timeout_ticks <= csr_data;
            default: ;
         endcase
      end
   end

   cicm_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_data),
      .full      (fe_full),
      .link      (link),
      .take      (take)
   );

   cicm_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .link      (link),
      .take      (take),
      .init_busy (init_busy),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: src/cicm_checker.sv
`include "can_id_change_monitor_defines.svh"

module cicm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_full,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input cicm_pkg::rsp_item_type          rsp_data
);
   import cicm_pkg::*;

   `CICM_ASSERT_NEXT(a_reset_blocks_input, reset, req_full && rsp_empty)
   `CICM_ASSERT_NOW(a_removal_clean, !rsp_empty && rsp_data.record_kind == REC_REMOVE,
      rsp_data.line_payload == 64'd0 && rsp_data.changed_bits == 64'd0
      && rsp_data.line_len == 4'd0)
   `CICM_ASSERT_NOW(a_delta_range, !rsp_empty, rsp_data.delta_ticks <= DELTA_MAX)
   `CICM_ASSERT_NEXT(a_rsp_holds, !reset && !rsp_empty && !rsp_pop, !rsp_empty || reset)

endmodule

bind can_id_change_monitor cicm_checker u_cicm_checker (.*);
